// ===== src/ufhp_pkg.sv =====
package ufhp_pkg;

  localparam int unsigned MAX_FRAME_DEF = 2048;
  localparam int unsigned OUT_W         = 12;

  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [OUT_W-1:0] payload_offset;
    logic [OUT_W-1:0] payload_length;
  } out_item_t;

  // held input beat handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } beat_t;

  // verdict handed to the result register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } verdict_t;

endpackage

// ===== src/ufhp_in_stage.sv =====
module ufhp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ufhp_pkg::in_item_t in_data,
  output logic               in_stall,
  input  logic               advance,
  output ufhp_pkg::beat_t    beat
);
  import ufhp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign beat.valid = valid_r;
  assign beat.item  = item_r;

endmodule

// ===== src/ufhp_parse.sv =====
module ufhp_parse #(
  parameter int unsigned MAX_FRAME = ufhp_pkg::MAX_FRAME_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ufhp_pkg::beat_t    beat,
  input  logic               out_free,
  input  logic [15:0]        match_port,
  output logic               advance,
  output ufhp_pkg::verdict_t verdict
);
  import ufhp_pkg::*;

  localparam int unsigned PW = $clog2(MAX_FRAME + 1);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned OW = (CW > OUT_W) ? CW : OUT_W;

  typedef enum logic [2:0] {
    PH_ETH, PH_VLAN, PH_IPV4, PH_IPV6, PH_UDP, PH_DONE, PH_SKIP
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   type_r, type_nxt;
  logic [PW-1:0] l3_r, l3_nxt;
  logic [5:0]    hdr_r, hdr_nxt;
  logic [PW-1:0] udp_r, udp_nxt;
  logic [7:0]    port_hi_r, port_hi_nxt;
  logic          checks_r, checks_nxt;

  logic [PW-1:0] pos_inc;
  logic [PW-1:0] rel;
  logic [PW-1:0] rel_udp;
  logic [15:0]   type_full;
  logic [7:0]    b;
  logic          fire_last;
  logic          acc;
  logic [OW-1:0] off_w, len_w, diff_w;

  function automatic phase_t next_phase(input logic [15:0] t);
    phase_t p;
    if (t == ETYPE_VLAN || t == ETYPE_QINQ) begin
      p = PH_VLAN;
    end else if (t == ETYPE_IPV4) begin
      p = PH_IPV4;
    end else if (t == ETYPE_IPV6) begin
      p = PH_IPV6;
    end else begin
      p = PH_SKIP;
    end
    return p;
  endfunction

  // a last byte needs room in the result register; other bytes never wait
  assign advance   = beat.valid && (!beat.item.last_byte || out_free);
  assign fire_last = advance && beat.item.last_byte;
  assign b         = beat.item.frame_byte;
  assign pos_inc   = pos_r + PW'(1);
  assign rel       = pos_r - l3_r;
  assign rel_udp   = pos_r - udp_r;
  assign type_full = {type_r[15:8], b};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    l3_nxt      = l3_r;
    hdr_nxt     = hdr_r;
    udp_nxt     = udp_r;
    port_hi_nxt = port_hi_r;
    checks_nxt  = checks_r;

    if (advance) begin
      if (pos_r >= PW'(MAX_FRAME)) begin
        // overlong: counter holds at the limit
        phase_nxt  = PH_SKIP;
        checks_nxt = 1'b0;
      end else begin
        pos_nxt = pos_inc;
        unique case (phase_r)
          PH_ETH: begin
            if (pos_r == PW'(12)) begin
              type_nxt = {b, 8'h00};
            end else if (pos_r == PW'(13)) begin
              type_nxt  = type_full;
              l3_nxt    = pos_inc;
              phase_nxt = next_phase(type_full);
              if (phase_nxt == PH_SKIP) checks_nxt = 1'b0;
            end
          end
          PH_VLAN: begin
            if (rel == PW'(2)) begin
              type_nxt = {b, 8'h00};
            end else if (rel == PW'(3)) begin
              type_nxt  = type_full;
              l3_nxt    = pos_inc;
              phase_nxt = next_phase(type_full);
              if (phase_nxt == PH_SKIP) checks_nxt = 1'b0;
            end
          end
          PH_IPV4: begin
            if (rel == '0) begin
              hdr_nxt = {b[3:0], 2'b00};
              if (hdr_nxt < 6'd20) begin
                phase_nxt  = PH_SKIP;
                checks_nxt = 1'b0;
              end
            end else if (rel == PW'(9)) begin
              if (b != PROTO_UDP) begin
                phase_nxt  = PH_SKIP;
                checks_nxt = 1'b0;
              end
            end else if (rel + PW'(1) == PW'(hdr_r)) begin
              udp_nxt   = pos_inc;
              phase_nxt = PH_UDP;
            end
          end
          PH_IPV6: begin
            if (rel == PW'(6)) begin
              if (b != PROTO_UDP) begin
                phase_nxt  = PH_SKIP;
                checks_nxt = 1'b0;
              end
            end else if (rel == PW'(39)) begin
              udp_nxt   = pos_inc;
              phase_nxt = PH_UDP;
            end
          end
          PH_UDP: begin
            if (rel_udp == PW'(2)) begin
              port_hi_nxt = b;
            end else if (rel_udp == PW'(3)) begin
              if ({port_hi_r, b} != match_port) begin
                phase_nxt  = PH_SKIP;
                checks_nxt = 1'b0;
              end
            end else if (rel_udp == PW'(7)) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE, PH_SKIP: ;
          default: ;
        endcase
      end
    end

    // verdict from the state after this byte
    acc    = (phase_nxt == PH_DONE) && checks_nxt;
    off_w  = OW'(udp_nxt) + OW'(8);
    len_w  = OW'(pos_r) + OW'(1);
    diff_w = len_w - off_w;

    verdict.valid               = fire_last;
    verdict.item.accepted       = acc;
    verdict.item.payload_offset = acc ? off_w[OUT_W-1:0] : '0;
    verdict.item.payload_length = acc ? diff_w[OUT_W-1:0] : '0;

    if (fire_last) begin
      phase_nxt   = PH_ETH;
      pos_nxt     = '0;
      type_nxt    = '0;
      l3_nxt      = '0;
      hdr_nxt     = '0;
      udp_nxt     = '0;
      port_hi_nxt = '0;
      checks_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ETH;
      pos_r     <= '0;
      type_r    <= '0;
      l3_r      <= '0;
      hdr_r     <= '0;
      udp_r     <= '0;
      port_hi_r <= '0;
      checks_r  <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      type_r    <= type_nxt;
      l3_r      <= l3_nxt;
      hdr_r     <= hdr_nxt;
      udp_r     <= udp_nxt;
      port_hi_r <= port_hi_nxt;
      checks_r  <= checks_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_FRAME))
    else $error("byte position beyond frame limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire_last |=> (pos_r == '0) && (phase_r == PH_ETH) && checks_r)
    else $error("frame state not cleared after last beat");

  a_fail_skips: assert property (@(posedge clk) disable iff (!rst_n)
    !checks_r |-> (phase_r == PH_SKIP))
    else $error("failed check without skip phase");

  a_acc_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_last && acc) |-> (off_w >= OW'(42)) && (len_w >= off_w))
    else $error("accepted verdict with impossible offset");

endmodule

// ===== src/ufhp_out_reg.sv =====
module ufhp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  ufhp_pkg::verdict_t  verdict,
  input  logic                out_stall,
  output logic                out_free,
  output logic                out_valid,
  output ufhp_pkg::out_item_t out_data
);
  import ufhp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (verdict.valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      data_r <= verdict.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/udp_feed_header_parser_unit.sv =====
// channel | dir | handshake          | beat
// in_     | in  | in_valid/in_stall  | one frame byte and last mark
// out_    | out | out_valid/out_stall| one verdict per frame
// cfg_    | in  | cfg_valid/cfg_ready| UDP destination port
//
// One byte per cycle unless a last byte waits for room; the verdict is put
// in the result register via the input register, then the parse logic.
// Rate is set by the single parse pass between input and result registers.
// rst_n is synchronous: frame state back to the Ethernet phase, port to 0.
// While out_stall holds a verdict, non-last bytes keep flowing; a last byte
// waits in the input register until the result register frees.
module udp_feed_header_parser_unit #(
  parameter int unsigned MAX_FRAME = ufhp_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ufhp_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output ufhp_pkg::out_item_t out_data,
  input  logic                out_stall,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  output logic                cfg_ready
);
  import ufhp_pkg::*;

  beat_t       beat;
  verdict_t    verdict;
  logic        advance;
  logic        out_free;
  logic [15:0] match_port_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      match_port_r <= cfg_data;
    end
  end

  ufhp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (advance),
    .beat     (beat)
  );

  ufhp_parse #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .out_free   (out_free),
    .match_port (match_port_r),
    .advance    (advance),
    .verdict    (verdict)
  );

  ufhp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .verdict   (verdict),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ufhp_pkg::*;

  localparam int unsigned MAX_FRAME = MAX_FRAME_DEF;

  typedef enum logic [1:0] {NET_IPV4, NET_IPV6, NET_OTHER} net_e;
  typedef enum logic [2:0] {
    ST_ETH, ST_TAG, ST_IPV4, ST_IPV6, ST_UDP, ST_DONE, ST_SKIP
  } walk_e;

  typedef struct packed {
    net_e        net;
    logic [3:0]  tags;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic        port_ok;
    logic [11:0] pay;
    logic [11:0] cut;     // 0: frame kept whole
    logic        typed;
    out_item_t   want;
  } frame_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t want;
  } typed_verdict_t;

  localparam out_item_t REJECT = '{1'b0, 12'd0, 12'd0};
  localparam int N_ROWS = 20;
  localparam frame_row_t FRAME_PLAN [N_ROWS] = '{
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b1, 12'd0,    12'd0,  1'b1, '{1'b1, 12'd42, 12'd0}},
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b1, 12'd18,   12'd0,  1'b1, '{1'b1, 12'd42, 12'd18}},
    '{NET_IPV6,  4'd0, 4'd0,  8'd17, 1'b1, 12'd5,    12'd0,  1'b1, '{1'b1, 12'd62, 12'd5}},
    '{NET_IPV4,  4'd0, 4'd15, 8'd17, 1'b1, 12'd3,    12'd0,  1'b1, '{1'b1, 12'd82, 12'd3}},
    '{NET_IPV4,  4'd1, 4'd5,  8'd17, 1'b1, 12'd0,    12'd0,  1'b1, '{1'b1, 12'd46, 12'd0}},
    '{NET_IPV6,  4'd2, 4'd0,  8'd17, 1'b1, 12'd7,    12'd0,  1'b1, '{1'b1, 12'd70, 12'd7}},
    '{NET_IPV4,  4'd0, 4'd0,  8'd17, 1'b1, 12'd4,    12'd0,  1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd4,  8'd17, 1'b1, 12'd4,    12'd0,  1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd5,  8'd6,  1'b1, 12'd4,    12'd0,  1'b1, REJECT},
    '{NET_IPV6,  4'd0, 4'd0,  8'd58, 1'b1, 12'd4,    12'd0,  1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b0, 12'd4,    12'd0,  1'b1, REJECT},
    '{NET_OTHER, 4'd0, 4'd5,  8'd17, 1'b1, 12'd10,   12'd0,  1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b1, 12'd10,   12'd1,  1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b1, 12'd10,   12'd14, 1'b1, REJECT},
    '{NET_IPV4,  4'd0, 4'd5,  8'd17, 1'b1, 12'd0,    12'd41, 1'b1, REJECT},
    '{NET_IPV6,  4'd1, 4'd0,  8'd17, 1'b1, 12'd0,    12'd65, 1'b1, REJECT},
    '{NET_IPV4,  4'd6, 4'd9,  8'd17, 1'b1, 12'd11,   12'd0,  1'b0, REJECT},
    '{NET_IPV6,  4'd3, 4'd0,  8'd17, 1'b1, 12'd20,   12'd0,  1'b0, REJECT},
    '{NET_IPV4,  4'd2, 4'd7,  8'd17, 1'b1, 12'd0,    12'd0,  1'b0, REJECT},
    '{NET_OTHER, 4'd2, 4'd5,  8'd17, 1'b1, 12'd6,    12'd0,  1'b0, REJECT}
  };

  localparam int SEND_GAP_PCT [4] = '{0, 52, 0, 28};
  localparam int STALL_PCT    [4] = '{0, 0, 52, 28};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        cfg_ready;

  udp_feed_header_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready)
  );

  // predictor state
  logic [15:0] match_port_q;
  int unsigned fp_pos, fp_l3, fp_ihl_bytes, fp_udp;
  walk_e       fp_phase;
  logic [15:0] fp_type;
  logic [7:0]  fp_port_hi;
  logic        fp_ok;

  out_item_t      verdicts_due [$];
  typed_verdict_t typed_due [$];
  logic [7:0]     frame_bytes [$];

  int send_gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int verdicts_seen = 0;
  int accepted_seen = 0;
  int ports_set = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic restart_frame();
    fp_pos = 0;
    fp_phase = ST_ETH;
    fp_type = '0;
    fp_l3 = 0;
    fp_ihl_bytes = 0;
    fp_udp = 0;
    fp_port_hi = '0;
    fp_ok = 1'b1;
  endtask

  task automatic drop_frame();
    fp_ok = 1'b0;
    fp_phase = ST_SKIP;
  endtask

  task automatic route_type(input int unsigned next_start);
    fp_l3 = next_start;
    if (fp_type == ETYPE_VLAN || fp_type == ETYPE_QINQ) fp_phase = ST_TAG;
    else if (fp_type == ETYPE_IPV4) fp_phase = ST_IPV4;
    else if (fp_type == ETYPE_IPV6) fp_phase = ST_IPV6;
    else drop_frame();
  endtask

  task automatic predict_verdict(input in_item_t it, output logic has, output out_item_t v);
    int unsigned p, rel;
    logic [7:0] b;
    b = it.frame_byte;
    p = fp_pos;
    has = 1'b0;
    v = REJECT;
    if (p >= MAX_FRAME) begin
      drop_frame();
    end else begin
      case (fp_phase)
        ST_ETH: begin
          if (p == 12) fp_type = {b, 8'h00};
          else if (p == 13) begin
            fp_type[7:0] = b;
            route_type(14);
          end
        end
        ST_TAG: begin
          rel = p - fp_l3;
          if (rel == 2) fp_type = {b, 8'h00};
          else if (rel == 3) begin
            fp_type[7:0] = b;
            route_type(p + 1);
          end
        end
        ST_IPV4: begin
          rel = p - fp_l3;
          if (rel == 0) begin
            fp_ihl_bytes = int'(b[3:0]) * 4;
            if (fp_ihl_bytes < 20) drop_frame();
          end else if (rel == 9) begin
            if (b != PROTO_UDP) drop_frame();
          end else if (rel + 1 == fp_ihl_bytes) begin
            fp_udp = p + 1;
            fp_phase = ST_UDP;
          end
        end
        ST_IPV6: begin
          rel = p - fp_l3;
          if (rel == 6) begin
            if (b != PROTO_UDP) drop_frame();
          end else if (rel == 39) begin
            fp_udp = p + 1;
            fp_phase = ST_UDP;
          end
        end
        ST_UDP: begin
          rel = p - fp_udp;
          if (rel == 2) fp_port_hi = b;
          else if (rel == 3) begin
            if ({fp_port_hi, b} != match_port_q) drop_frame();
          end else if (rel == 7) begin
            fp_phase = ST_DONE;
          end
        end
        default: ;
      endcase
      fp_pos = p + 1;
    end
    if (it.last_byte) begin
      has = 1'b1;
      if (fp_phase == ST_DONE && fp_ok) begin
        v.accepted = 1'b1;
        v.payload_offset = 12'(fp_udp + 8);
        v.payload_length = 12'(p + 1 - (fp_udp + 8));
      end
      restart_frame();
    end
  endtask

  // result check first, then predict from the input beat of the same edge
  always @(posedge clk) begin : watch
    logic           has;
    out_item_t      v;
    out_item_t      want;
    typed_verdict_t tv;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (out_data.accepted === 1'b1) accepted_seen++;
        if (verdicts_due.size() == 0) begin
          log_error($sformatf("unexpected verdict acc=%0b off=%0d len=%0d",
                              out_data.accepted, out_data.payload_offset,
                              out_data.payload_length));
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.accepted !== want.accepted ||
              out_data.payload_offset !== want.payload_offset ||
              out_data.payload_length !== want.payload_length)
            log_error($sformatf("verdict exp acc=%0b off=%0d len=%0d, got acc=%0b off=%0d len=%0d",
                                want.accepted, want.payload_offset, want.payload_length,
                                out_data.accepted, out_data.payload_offset,
                                out_data.payload_length));
        end
      end
      if (in_valid && !in_stall) begin
        predict_verdict(in_data, has, v);
        if (has) begin
          if (typed_due.size() != 0) begin
            tv = typed_due.pop_front();
            if (tv.typed) v = tv.want;
          end
          verdicts_due.push_back(v);
        end
      end
    end
  end

  always @(posedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  task automatic send_beat(input in_item_t it);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame();
    in_item_t it;
    foreach (frame_bytes[i]) begin
      it.frame_byte = frame_bytes[i];
      it.last_byte = (i == frame_bytes.size() - 1);
      send_beat(it);
    end
    frames_sent++;
  endtask

  task automatic push16(input logic [15:0] w);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endtask

  task automatic trim_frame(input int n);
    if (n != 0)
      while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endtask

  task automatic build_frame(input net_e net, input int tags, input int ihl,
                             input logic [7:0] proto, input logic [15:0] dport,
                             input int pay);
    logic [15:0] etype;
    int hdr;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    for (int t = 0; t < tags; t++) begin
      push16((t % 2) ? ETYPE_VLAN : ETYPE_QINQ);
      push16(16'($urandom));
    end
    case (net)
      NET_IPV4: etype = ETYPE_IPV4;
      NET_IPV6: etype = ETYPE_IPV6;
      default: begin
        do etype = 16'($urandom);
        while (etype inside {ETYPE_VLAN, ETYPE_QINQ, ETYPE_IPV4, ETYPE_IPV6});
      end
    endcase
    push16(etype);
    if (net == NET_IPV6) begin
      for (int k = 0; k < 40; k++)
        frame_bytes.push_back(k == 6 ? proto : 8'($urandom));
    end else begin
      // a bad IHL still gets a 20-byte header so the rest looks plausible
      hdr = (ihl < 5) ? 20 : ihl * 4;
      for (int k = 0; k < hdr; k++)
        frame_bytes.push_back(k == 0 ? {4'($urandom_range(15)), 4'(ihl)} :
                              k == 9 ? proto : 8'($urandom));
    end
    push16(16'($urandom));
    push16(dport);
    repeat (4) frame_bytes.push_back(8'($urandom));
    repeat (pay) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic random_frame();
    int r, tags, ihl, pay;
    net_e net;
    logic [7:0] proto;
    logic [15:0] dport;
    r = $urandom_range(99);
    net = $urandom_range(1) ? NET_IPV6 : NET_IPV4;
    tags = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(2);
    ihl = $urandom_range(15, 5);
    proto = PROTO_UDP;
    dport = match_port_q;
    pay = $urandom_range(24);
    if (r < 8) begin
      dport = match_port_q ^ 16'($urandom_range(65535, 1));
    end else if (r < 12) begin
      proto = 8'($urandom_range(255));
      if (proto == PROTO_UDP) proto = 8'd6;
    end else if (r < 16) begin
      net = NET_IPV4;
      ihl = $urandom_range(4);
    end else if (r < 20) begin
      net = NET_OTHER;
    end
    build_frame(net, tags, ihl, proto, dport, pay);
    if (r >= 20 && r < 27) begin
      trim_frame($urandom_range(frame_bytes.size() - 1, 1));
    end else if (r >= 27 && r < 31) begin
      frame_bytes.delete();
      repeat ($urandom_range(60, 1)) frame_bytes.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic write_port(input logic [15:0] p);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    match_port_q = p;
    ports_set++;
  endtask

  task automatic drain_verdicts();
    int w;
    in_valid <= 1'b0;
    @(posedge clk);
    for (w = 0; verdicts_due.size() != 0 && w < 5000; w++) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      log_error($sformatf("%0d verdicts never arrived", verdicts_due.size()));
      verdicts_due.delete();
    end
    // leave margin
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ph, b0, f0;
    logic [15:0] p;
    typed_verdict_t tv;
    match_port_q = '0;
    restart_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset port value
    foreach (FRAME_PLAN[i]) begin
      build_frame(FRAME_PLAN[i].net, FRAME_PLAN[i].tags, FRAME_PLAN[i].ihl,
                  FRAME_PLAN[i].proto,
                  FRAME_PLAN[i].port_ok ? match_port_q : match_port_q ^ 16'h5A5A,
                  FRAME_PLAN[i].pay);
      trim_frame(FRAME_PLAN[i].cut);
      tv.typed = FRAME_PLAN[i].typed;
      tv.want = FRAME_PLAN[i].want;
      typed_due.push_back(tv);
      send_frame();
    end
    drain_verdicts();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       p = 16'hFFFF;
        2:       p = 16'h0000;
        default: p = 16'($urandom);
      endcase
      write_port(p);
      send_gap_pct = SEND_GAP_PCT[ph % 4];
      stall_pct = STALL_PCT[ph % 4];
      b0 = bytes_sent;
      f0 = frames_sent;
      while (bytes_sent - b0 < 48 || frames_sent - f0 < 1) random_frame();
      drain_verdicts();
    end

    $display("Ran %0d frames (%0d bytes) over %0d port settings, idle and stall mixes",
             frames_sent, bytes_sent, ports_set);
    $display("Checked %0d verdicts, %0d accepted; %0d errors",
             verdicts_seen, accepted_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
